// ===== hw/rtl/tad_pkg.sv =====
// tamper alarm detector package: item, config and result types, cause and register codes
// no dependencies; used by every module of the detector
package tad_pkg;

  localparam logic [31:0] TOUCH_REFIRE_MS = 32'd2000;
  localparam logic [31:0] KNOCK_GAP_MS    = 32'd150;
  localparam logic [31:0] MOTION_HOLD_MS  = 32'd3000;
  localparam logic [31:0] COOLDOWN_MS     = 32'd30000;

  // motion thresholds: 0.10 g and 0.35 gyro units
  localparam logic [15:0] MOTION_ACCEL_LIMIT = 16'd100;
  localparam logic [15:0] MOTION_GYRO_LIMIT  = 16'd35;

  localparam logic [3:0] KNOCK_COUNT_MAX = 4'd15;

  localparam logic [11:0] SPEED_LIMIT_RST       = 12'd50;
  localparam logic [15:0] TOUCH_ACCEL_LIMIT_RST = 16'd200;
  localparam logic [15:0] TOUCH_GYRO_LIMIT_RST  = 16'd100;
  localparam logic [15:0] KNOCK_ACCEL_LIMIT_RST = 16'd500;
  localparam logic [15:0] KNOCK_GYRO_LIMIT_RST  = 16'd300;
  localparam logic [3:0]  KNOCKS_NEEDED_RST     = 4'd3;
  localparam logic [31:0] KNOCK_SPAN_MS_RST     = 32'd3000;
  localparam logic [31:0] TOUCH_HOLD_MS_RST     = 32'd1000;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_GPS    = 3'd1,
    CAUSE_TOUCH  = 3'd2,
    CAUSE_KNOCK  = 3'd3,
    CAUSE_MOTION = 3'd4
  } cause_t;

  typedef enum logic [2:0] {
    REG_SPEED_LIMIT       = 3'd0,
    REG_TOUCH_ACCEL_LIMIT = 3'd1,
    REG_TOUCH_GYRO_LIMIT  = 3'd2,
    REG_KNOCK_ACCEL_LIMIT = 3'd3,
    REG_KNOCK_GYRO_LIMIT  = 3'd4,
    REG_KNOCKS_NEEDED     = 3'd5,
    REG_KNOCK_SPAN_MS     = 3'd6,
    REG_TOUCH_HOLD_MS     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        is_armed;
    logic        is_locked;
    logic [31:0] settle_until_ms;
    logic [11:0] speed;
    logic        imu_ready;
    logic [15:0] accel_delta;
    logic [15:0] gyro_mag;
    logic        imu_moving;
  } item_t;

  typedef struct packed {
    logic [11:0] speed_limit;
    logic [15:0] touch_accel_limit;
    logic [15:0] touch_gyro_limit;
    logic [15:0] knock_accel_limit;
    logic [15:0] knock_gyro_limit;
    logic [3:0]  knocks_needed;
    logic [31:0] knock_span_ms;
    logic [31:0] touch_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic   alarm_fired;
    cause_t alarm_cause;
    logic   held_by_cooldown;
    logic   alarm_latched;
  } result_t;

endpackage

// ===== hw/rtl/tad_cfg.sv =====
// configuration register file of the tamper alarm detector
// depends on tad_pkg for cfg_t, register codes and reset values
module tad_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output tad_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit       <= tad_pkg::SPEED_LIMIT_RST;
      cfg.touch_accel_limit <= tad_pkg::TOUCH_ACCEL_LIMIT_RST;
      cfg.touch_gyro_limit  <= tad_pkg::TOUCH_GYRO_LIMIT_RST;
      cfg.knock_accel_limit <= tad_pkg::KNOCK_ACCEL_LIMIT_RST;
      cfg.knock_gyro_limit  <= tad_pkg::KNOCK_GYRO_LIMIT_RST;
      cfg.knocks_needed     <= tad_pkg::KNOCKS_NEEDED_RST;
      cfg.knock_span_ms     <= tad_pkg::KNOCK_SPAN_MS_RST;
      cfg.touch_hold_ms     <= tad_pkg::TOUCH_HOLD_MS_RST;
    end else if (cfg_we) begin
      unique case (tad_pkg::cfg_idx_t'(cfg_index))
        tad_pkg::REG_SPEED_LIMIT:       cfg.speed_limit       <= cfg_data[11:0];
        tad_pkg::REG_TOUCH_ACCEL_LIMIT: cfg.touch_accel_limit <= cfg_data[15:0];
        tad_pkg::REG_TOUCH_GYRO_LIMIT:  cfg.touch_gyro_limit  <= cfg_data[15:0];
        tad_pkg::REG_KNOCK_ACCEL_LIMIT: cfg.knock_accel_limit <= cfg_data[15:0];
        tad_pkg::REG_KNOCK_GYRO_LIMIT:  cfg.knock_gyro_limit  <= cfg_data[15:0];
        tad_pkg::REG_KNOCKS_NEEDED:     cfg.knocks_needed     <= cfg_data[3:0];
        tad_pkg::REG_KNOCK_SPAN_MS:     cfg.knock_span_ms     <= cfg_data;
        tad_pkg::REG_TOUCH_HOLD_MS:     cfg.touch_hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tad_in_stage.sv =====
// input register stage: captures one word and holds it until the result stage takes it
// depends on tad_pkg for item_t
module tad_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tad_pkg::item_t  in_item,
  output logic            in_stall,
  input  logic            out_free,
  output tad_pkg::item_t  item,
  output logic            move
);

  logic r_valid;
  logic r_valid_next;
  logic accept;

  assign move     = r_valid && out_free;
  assign in_stall = r_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    r_valid_next = r_valid;
    if (accept) begin
      r_valid_next = 1'b1;
    end else if (move) begin
      r_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= r_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/tad_eval.sv =====
// detector evaluation: priority detectors, cooldown gate and the tracking state they keep
// depends on tad_pkg for item_t, cfg_t, result_t and timing constants
module tad_eval (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tad_pkg::item_t    item,
  input  tad_pkg::cfg_t     cfg,
  output tad_pkg::result_t  res
);

  logic [31:0] touch_start,      touch_start_next;
  logic        touch_active,     touch_active_next;
  logic [31:0] last_touch_fire,  last_touch_fire_next;
  logic [3:0]  knock_count,      knock_count_next;
  logic [31:0] first_knock_time, first_knock_time_next;
  logic [31:0] last_knock_time,  last_knock_time_next;
  logic [31:0] motion_start,     motion_start_next;
  logic        motion_active,    motion_active_next;
  logic [31:0] cooldown_until,   cooldown_until_next;
  logic        latched_flag,     latched_flag_next;

  always_comb begin
    tad_pkg::cause_t cause;
    logic        touch;
    logic        hit;
    logic        motion;
    logic [31:0] ts;
    logic [31:0] fk;
    logic [3:0]  kc;
    logic [31:0] ms;
    logic        fired;

    touch_start_next      = touch_start;
    touch_active_next     = touch_active;
    last_touch_fire_next  = last_touch_fire;
    knock_count_next      = knock_count;
    first_knock_time_next = first_knock_time;
    last_knock_time_next  = last_knock_time;
    motion_start_next     = motion_start;
    motion_active_next    = motion_active;
    cooldown_until_next   = cooldown_until;
    latched_flag_next     = latched_flag;
    cause  = tad_pkg::CAUSE_NONE;
    touch  = (item.accel_delta > cfg.touch_accel_limit) ||
             (item.gyro_mag > cfg.touch_gyro_limit);
    hit    = (item.accel_delta > cfg.knock_accel_limit) ||
             (item.gyro_mag > cfg.knock_gyro_limit);
    motion = (item.accel_delta > tad_pkg::MOTION_ACCEL_LIMIT) ||
             (item.gyro_mag > tad_pkg::MOTION_GYRO_LIMIT) || item.imu_moving;
    ts     = touch_active ? touch_start : item.now_ms;
    fk     = (knock_count == 4'd0) ? item.now_ms : first_knock_time;
    kc     = (knock_count < tad_pkg::KNOCK_COUNT_MAX) ? knock_count + 4'd1 : knock_count;
    ms     = motion_active ? motion_start : item.now_ms;
    fired  = 1'b0;

    if (item.is_armed && item.is_locked) begin
      if ((item.now_ms < item.settle_until_ms) || (item.speed >= cfg.speed_limit)) begin
        knock_count_next      = 4'd0;
        first_knock_time_next = '0;
        motion_active_next    = 1'b0;
        motion_start_next     = '0;
        touch_active_next     = 1'b0;
        touch_start_next      = '0;
        if (item.now_ms >= item.settle_until_ms) begin
          cause = tad_pkg::CAUSE_GPS;
        end
      end else if (item.imu_ready) begin
        // touch: debounce from first sighting, then refire spacing
        if (touch) begin
          if (((item.now_ms - ts) >= cfg.touch_hold_ms) &&
              ((item.now_ms - last_touch_fire) >= tad_pkg::TOUCH_REFIRE_MS)) begin
            last_touch_fire_next = item.now_ms;
            touch_active_next    = 1'b0;
            touch_start_next     = '0;
            cause                = tad_pkg::CAUSE_TOUCH;
          end else begin
            touch_active_next = 1'b1;
            touch_start_next  = ts;
          end
        end else begin
          touch_active_next = 1'b0;
          touch_start_next  = '0;
        end

        // knock: spaced hits counted inside the window from the first one
        if (cause == tad_pkg::CAUSE_NONE) begin
          if (hit && ((item.now_ms - last_knock_time) >= tad_pkg::KNOCK_GAP_MS)) begin
            last_knock_time_next  = item.now_ms;
            first_knock_time_next = fk;
            if ((kc >= cfg.knocks_needed) && ((item.now_ms - fk) <= cfg.knock_span_ms)) begin
              knock_count_next = 4'd0;
              cause            = tad_pkg::CAUSE_KNOCK;
            end else begin
              knock_count_next = kc;
            end
          end
        end

        // sustained motion, with stale knock sequence dropped first
        if (cause == tad_pkg::CAUSE_NONE) begin
          if ((knock_count_next != 4'd0) &&
              ((item.now_ms - first_knock_time_next) > cfg.knock_span_ms)) begin
            knock_count_next = 4'd0;
          end
          if (motion) begin
            if ((item.now_ms - ms) >= tad_pkg::MOTION_HOLD_MS) begin
              motion_active_next = 1'b0;
              motion_start_next  = '0;
              cause              = tad_pkg::CAUSE_MOTION;
            end else begin
              motion_active_next = 1'b1;
              motion_start_next  = ms;
            end
          end else begin
            motion_active_next = 1'b0;
            motion_start_next  = '0;
          end
        end
      end
    end

    if ((cause != tad_pkg::CAUSE_NONE) && (item.now_ms >= cooldown_until)) begin
      fired               = 1'b1;
      latched_flag_next   = 1'b1;
      cooldown_until_next = item.now_ms + tad_pkg::COOLDOWN_MS;
    end

    res.alarm_fired      = fired;
    res.alarm_cause      = cause;
    res.held_by_cooldown = (cause != tad_pkg::CAUSE_NONE) && !fired;
    res.alarm_latched    = latched_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_start      <= '0;
      touch_active     <= 1'b0;
      last_touch_fire  <= '0;
      knock_count      <= 4'd0;
      first_knock_time <= '0;
      last_knock_time  <= '0;
      motion_start     <= '0;
      motion_active    <= 1'b0;
      cooldown_until   <= '0;
      latched_flag     <= 1'b0;
    end else if (en) begin
      touch_start      <= touch_start_next;
      touch_active     <= touch_active_next;
      last_touch_fire  <= last_touch_fire_next;
      knock_count      <= knock_count_next;
      first_knock_time <= first_knock_time_next;
      last_knock_time  <= last_knock_time_next;
      motion_start     <= motion_start_next;
      motion_active    <= motion_active_next;
      cooldown_until   <= cooldown_until_next;
      latched_flag     <= latched_flag_next;
    end
  end

endmodule

// ===== hw/rtl/tad_out_stage.sv =====
// result register stage: holds one result word until the consumer takes it
// depends on tad_pkg for result_t
module tad_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tad_pkg::result_t  res,
  input  logic              out_stall,
  output logic              out_valid,
  output tad_pkg::result_t  res_q,
  output logic              out_free
);

  logic out_valid_next;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

// ===== hw/rtl/tamper_alarm_detector_top.sv =====
// a word accepted into the input register has its result registered in the result register once that stage is free
// throughput: one word per cycle while out_stall is low; input register and result register split the two channels
// the detector state updates in the same cycle the result register loads
// reset (rst, synchronous, active high): config back to defaults, detector state,
// cooldown and latch cleared, both stages empty
module tamper_alarm_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        is_armed,
  input  logic        is_locked,
  input  logic [31:0] settle_until_ms,
  input  logic [11:0] speed,
  input  logic        imu_ready,
  input  logic [15:0] accel_delta,
  input  logic [15:0] gyro_mag,
  input  logic        imu_moving,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        alarm_fired,
  output logic [2:0]  alarm_cause,
  output logic        held_by_cooldown,
  output logic        alarm_latched
);

  tad_pkg::cfg_t    cfg;
  tad_pkg::item_t   in_item;
  tad_pkg::item_t   item;
  tad_pkg::result_t res;
  tad_pkg::result_t res_q;
  logic             move;
  logic             out_free;

  always_comb begin
    in_item.now_ms          = now_ms;
    in_item.is_armed        = is_armed;
    in_item.is_locked       = is_locked;
    in_item.settle_until_ms = settle_until_ms;
    in_item.speed           = speed;
    in_item.imu_ready       = imu_ready;
    in_item.accel_delta     = accel_delta;
    in_item.gyro_mag        = gyro_mag;
    in_item.imu_moving      = imu_moving;
  end

  tad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tad_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_free (out_free),
    .item     (item),
    .move     (move)
  );

  tad_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .en   (move),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  tad_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .out_free  (out_free)
  );

  assign alarm_fired      = res_q.alarm_fired;
  assign alarm_cause      = res_q.alarm_cause;
  assign held_by_cooldown = res_q.held_by_cooldown;
  assign alarm_latched    = res_q.alarm_latched;

`ifndef SYNTH
  a_fired_xor_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(alarm_fired && held_by_cooldown))
    else $error("fired and held both set");

  a_trip_has_cause: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (alarm_fired || held_by_cooldown)) |-> (alarm_cause != tad_pkg::CAUSE_NONE))
    else $error("alarm without a cause");

  a_fire_latches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_fired) |-> alarm_latched)
    else $error("fired alarm not latched");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("stages not empty after reset");
`endif

endmodule
